/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key debounce design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: same-cycle implication violated.");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle implication violated.");

`endif

/* sv/kdlp_pkg.sv */
// ---------------------------------------------------------------------------
// Key debounce package
// Widths, reset values, register indexes and shared types.
// ---------------------------------------------------------------------------
package kdlp_pkg;

   localparam int NumKeysDefault = 6;
   localparam int KeyW = 3;
   localparam int TimeW = 32;
   localparam int CfgW = 16;

   localparam logic [CfgW-1:0] DebounceTimeReset = 16'd30;
   localparam logic [CfgW-1:0] LongPressTimeReset = 16'd2500;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE_TIME   = 1'b0,
      CSR_LONG_PRESS_TIME = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             debounced;
      logic             prev_raw;
      logic             long_done;
      logic [TimeW-1:0] change_time;
      logic [TimeW-1:0] press_time;
   } key_entry_type;

   typedef struct packed {
      key_entry_type entry;
      logic          emit;
      logic          pressed;
      logic          is_long;
   } step_result_type;

endpackage

/* sv/kdlp_if.sv */
// ---------------------------------------------------------------------------
// Key debounce channels
// Sample, event and register write channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface kdlp_req_if;
   logic                       valid;
   logic                       ready;
   logic [kdlp_pkg::KeyW-1:0]  key_index;
   logic                       raw_pressed;
   logic [kdlp_pkg::TimeW-1:0] now_time;

   modport source (output valid, key_index, raw_pressed, now_time, input ready);
   modport sink (input valid, key_index, raw_pressed, now_time, output ready);
endinterface

interface kdlp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [kdlp_pkg::KeyW-1:0] event_key;
   logic                      event_pressed;
   logic                      event_long;

   modport source (output valid, event_key, event_pressed, event_long, input ready);
   modport sink (input valid, event_key, event_pressed, event_long, output ready);
endinterface

interface kdlp_csr_if;
   logic                      valid;
   logic                      ready;
   logic [0:0]                reg_index;
   logic [kdlp_pkg::CfgW-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* sv/kdlp_state_mem.sv */
// ---------------------------------------------------------------------------
// Key state memory
// Per-key state store with registered read and per-entry valid bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kdlp_state_mem #(
   parameter int NUM_KEYS = kdlp_pkg::NumKeysDefault,
   parameter int ADDR_W = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  kdlp_pkg::key_entry_type wr_data,
   output kdlp_pkg::key_entry_type rd_data
);

   localparam int Depth = 1 << ADDR_W;

   kdlp_pkg::key_entry_type mem [Depth];
   logic [Depth-1:0]        valid_ff;
   kdlp_pkg::key_entry_type rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry never written reads as a released key with zero times.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   // The number of written entries can never exceed the number of keys.
   `ASSERT_IMPLY(a_valid_count, clock, reset, 1'b1, $countones(valid_ff) <= NUM_KEYS)

endmodule

/* sv/kdlp_update.sv */
// ---------------------------------------------------------------------------
// Key state update
// Debounce and long-press decision for one sample against its key state.
// ---------------------------------------------------------------------------
module kdlp_update (
   input  logic                       raw_pressed,
   input  logic [kdlp_pkg::TimeW-1:0] now_time,
   input  logic [kdlp_pkg::CfgW-1:0]  debounce_time,
   input  logic [kdlp_pkg::CfgW-1:0]  long_press_time,
   input  kdlp_pkg::key_entry_type    entry,
   output kdlp_pkg::step_result_type  result
);

   logic [kdlp_pkg::TimeW-1:0] change_time;
   logic [kdlp_pkg::TimeW-1:0] held_time;
   logic [kdlp_pkg::TimeW-1:0] pressed_time;
   logic                       level_due;
   logic                       long_due;

   always_comb begin
      change_time = (raw_pressed != entry.prev_raw) ? now_time : entry.change_time;
      held_time = now_time - change_time;
      pressed_time = now_time - entry.press_time;
      level_due = (held_time >= kdlp_pkg::TimeW'(debounce_time))
                  && (raw_pressed != entry.debounced);
      long_due = entry.debounced && !entry.long_done
                 && (pressed_time >= kdlp_pkg::TimeW'(long_press_time));
   end

   always_comb begin
      result.entry = entry;
      result.entry.prev_raw = raw_pressed;
      result.entry.change_time = change_time;
      result.emit = 1'b0;
      result.pressed = 1'b0;
      result.is_long = 1'b0;
      priority if (level_due) begin
         result.entry.debounced = raw_pressed;
         result.entry.long_done = 1'b0;
         if (raw_pressed) begin
            result.entry.press_time = now_time;
         end
         result.emit = 1'b1;
         result.pressed = raw_pressed;
      end else if (long_due) begin
         result.entry.long_done = 1'b1;
         result.emit = 1'b1;
         result.pressed = 1'b1;
         result.is_long = 1'b1;
      end else begin
         result.emit = 1'b0;
      end
   end

endmodule

/* sv/key_debounce_long_press.sv */
// ---------------------------------------------------------------------------
// Key debounce with long-press detect, one sample per cycle unless a stalled event
// holds the update stage; per-key state is read, updated and written back with
// forwarding. Reset releases all keys and restores the 30 ms and 2500 ms times at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module key_debounce_long_press #(
   parameter int NUM_KEYS = kdlp_pkg::NumKeysDefault
) (
   input logic       clock,
   input logic       reset,
   kdlp_req_if.sink  req_ch,
   kdlp_rsp_if.source rsp_ch,
   kdlp_csr_if.sink  csr_ch
);

   localparam int AddrW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   logic [kdlp_pkg::CfgW-1:0]  debounce_time_ff;
   logic [kdlp_pkg::CfgW-1:0]  long_press_time_ff;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_inrange_ff;
   logic [kdlp_pkg::KeyW-1:0]  s1_key_ff;
   logic                       s1_raw_ff;
   logic [kdlp_pkg::TimeW-1:0] s1_now_ff;

   logic                       fwd_hit_ff;
   logic                       fwd_hit_in;
   kdlp_pkg::key_entry_type    fwd_data_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [kdlp_pkg::KeyW-1:0]  rsp_key_ff;
   logic                       rsp_pressed_ff;
   logic                       rsp_long_ff;

   logic                       req_accept;
   logic                       req_inrange;
   logic                       s1_adv;
   logic                       s1_wr;
   kdlp_pkg::key_entry_type    mem_rd_data;
   kdlp_pkg::key_entry_type    cur_entry;
   kdlp_pkg::step_result_type  step;

   // Register writes.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= kdlp_pkg::DebounceTimeReset;
         long_press_time_ff <= kdlp_pkg::LongPressTimeReset;
      end else if (csr_ch.valid) begin
         unique case (kdlp_pkg::csr_index_type'(csr_ch.reg_index))
            kdlp_pkg::CSR_DEBOUNCE_TIME: begin
               debounce_time_ff <= csr_ch.wdata;
            end
            kdlp_pkg::CSR_LONG_PRESS_TIME: begin
               long_press_time_ff <= csr_ch.wdata;
            end
         endcase
      end
   end

   // Pipeline control.
   always_comb begin
      req_inrange = int'(req_ch.key_index) < NUM_KEYS;
      s1_adv = s1_valid_ff && (!step.emit || !rsp_valid_ff || rsp_ch.ready);
      s1_wr = s1_adv && s1_inrange_ff;
      req_ch.ready = !s1_valid_ff || s1_adv;
      req_accept = req_ch.valid && req_ch.ready;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
      fwd_hit_in = s1_wr && (s1_key_ff == req_ch.key_index);
      rsp_valid_in = (s1_adv && s1_inrange_ff && step.emit)
                     || (rsp_valid_ff && !rsp_ch.ready);
      cur_entry = fwd_hit_ff ? fwd_data_ff : mem_rd_data;
   end

   kdlp_state_mem #(
      .NUM_KEYS(NUM_KEYS),
      .ADDR_W  (AddrW)
   ) u_state_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_accept),
      .rd_addr(AddrW'(req_ch.key_index)),
      .wr_en  (s1_wr),
      .wr_addr(AddrW'(s1_key_ff)),
      .wr_data(step.entry),
      .rd_data(mem_rd_data)
   );

   kdlp_update u_update (
      .raw_pressed    (s1_raw_ff),
      .now_time       (s1_now_ff),
      .debounce_time  (debounce_time_ff),
      .long_press_time(long_press_time_ff),
      .entry          (cur_entry),
      .result         (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end else if (s1_adv) begin
            fwd_hit_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_inrange_ff <= req_inrange;
         s1_key_ff <= req_ch.key_index;
         s1_raw_ff <= req_ch.raw_pressed;
         s1_now_ff <= req_ch.now_time;
         fwd_data_ff <= step.entry;
      end
      if (s1_adv && s1_inrange_ff && step.emit) begin
         rsp_key_ff <= s1_key_ff;
         rsp_pressed_ff <= step.pressed;
         rsp_long_ff <= step.is_long;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.event_key = rsp_key_ff;
   assign rsp_ch.event_pressed = rsp_pressed_ff;
   assign rsp_ch.event_long = rsp_long_ff;

   // A long-press event always reports the key as pressed.
   `ASSERT_IMPLY(a_long_is_pressed, clock, reset, rsp_valid_ff && rsp_long_ff, rsp_pressed_ff)
   // A new sample enters only while the sample ahead of it leaves the update stage.
   `ASSERT_IMPLY(a_accept_advance, clock, reset, req_accept && s1_valid_ff, s1_adv)
   // A forwarded entry always belongs to a sample in the update stage.
   `ASSERT_IMPLY(a_fwd_has_item, clock, reset, fwd_hit_ff, s1_valid_ff)
   // A stalled result holds the update stage, so no state is written meanwhile.
   `ASSERT_NEXT(a_stall_no_write, clock, reset,
      rsp_valid_ff && !rsp_ch.ready && s1_valid_ff && step.emit, s1_valid_ff)

endmodule
